### hw/rtl/sofd_pkg.sv
package sofd_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned FRAME_LEN_DEF = 16;
  localparam int unsigned INDEX_W       = 4;

  localparam logic [BYTE_W-1:0] SOF_RESET  = 8'hA5;
  localparam logic [7:0]        CRC8_SEED  = 8'hFF;
  localparam logic [7:0]        CRC8_POLY  = 8'h8C;
  localparam logic [15:0]       CRC16_SEED = 16'hFFFF;
  localparam logic [15:0]       CRC16_POLY = 16'h8408;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HUNT_RD,
    ST_HUNT_CMP,
    ST_CHK_RD,
    ST_CHK_USE,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_DROP
  } state_t;

  // Reflected CRC-8, one byte folded in bit by bit.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Reflected CRC-16, one byte folded in bit by bit.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### hw/rtl/sofd_win_ram.sv
module sofd_win_ram import sofd_pkg::*; #(
  parameter int unsigned DEPTH = FRAME_LEN_DEF,
  parameter int unsigned AW    = $clog2(FRAME_LEN_DEF)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/sof_crc_frame_deframer_unit.sv
// Flow: an accepted byte is stored in the window RAM, then the start-byte hunt reads the
// head entry and drops it while it is not the start byte. A full window is checked entry by
// entry through the window RAM's single read port and, if it passes, emitted entry by entry
// (stalling while the output is held), then slid by one byte before a new hunt; a failing
// window is slid the same way. New bytes are accepted only while the unit is idle.
// Reset (rst, synchronous) empties the window and loads the start byte with 0xA5.
module sof_crc_frame_deframer_unit import sofd_pkg::*; #(
  parameter int unsigned FRAME_LEN = FRAME_LEN_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [BYTE_W-1:0]        cfg_wr_data,   // sof_byte
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [BYTE_W-1:0]        s_axis_tdata,  // [7:0] rx_byte
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [15:0]              m_axis_tdata,  // [7:0] frame_byte, [11:8] byte_index
  output logic                     m_axis_tlast   // frame_last
);

  localparam int unsigned AW = $clog2(FRAME_LEN);
  localparam int unsigned FW = $clog2(FRAME_LEN + 1);

  localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(FRAME_LEN);
  localparam logic [AW-1:0] HEAD_LAST = AW'(FRAME_LEN - 1);
  localparam logic [AW-1:0] IDX_LAST  = AW'(FRAME_LEN - 1);
  localparam logic [AW-1:0] IDX_CRC8  = AW'(2);
  localparam logic [AW-1:0] IDX_CRC_L = AW'(FRAME_LEN - 2);
  localparam logic [FW-1:0] FILL_FULL = FW'(FRAME_LEN);

  state_t            state, state_next;
  logic [BYTE_W-1:0] sof;
  logic [AW-1:0]     head;
  logic [FW-1:0]     fill;
  logic [AW-1:0]     idx;
  logic [7:0]        c8;
  logic [15:0]       c16;
  logic              ok;
  logic              ok_next;

  logic [BYTE_W-1:0] out_byte;
  logic [INDEX_W-1:0] out_index;
  logic              out_last;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic [AW:0]       rd_sum;
  logic [AW:0]       wr_sum;
  logic              accept;
  logic              slot_free;
  logic              sof_hit;

  sofd_win_ram #(
    .DEPTH (FRAME_LEN),
    .AW    (AW)
  ) u_win (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (s_axis_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign slot_free = !m_axis_tvalid || m_axis_tready;
  assign sof_hit   = (rd_data == sof);

  // Circular window addressing: both sums stay below twice the depth.
  assign rd_sum  = {1'b0, head} + {1'b0, idx};
  assign rd_addr = (rd_sum >= DEPTH_X) ? AW'(rd_sum - DEPTH_X) : AW'(rd_sum);
  assign wr_sum  = {1'b0, head} + {1'b0, AW'(fill)};
  assign wr_addr = (wr_sum >= DEPTH_X) ? AW'(wr_sum - DEPTH_X) : AW'(wr_sum);

  assign ok_next = ok
                   && (idx != IDX_CRC8  || c8 == rd_data)
                   && (idx != IDX_CRC_L || c16[7:0] == rd_data)
                   && (idx != IDX_LAST  || c16[15:8] == rd_data);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_HUNT_RD;
      end
      ST_HUNT_RD: begin
        state_next = (fill == '0) ? ST_IDLE : ST_HUNT_CMP;
      end
      ST_HUNT_CMP: begin
        if (!sof_hit)                state_next = ST_HUNT_RD;
        else if (fill == FILL_FULL)  state_next = ST_CHK_RD;
        else                         state_next = ST_IDLE;
      end
      ST_CHK_RD: begin
        state_next = ST_CHK_USE;
      end
      ST_CHK_USE: begin
        if (idx == IDX_LAST) state_next = ok_next ? ST_EMIT_RD : ST_DROP;
        else                 state_next = ST_CHK_RD;
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (slot_free) state_next = (idx == IDX_LAST) ? ST_DROP : ST_EMIT_RD;
      end
      ST_DROP: begin
        state_next = ST_HUNT_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    unique case (state) inside
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        wr_en         = s_axis_tvalid;
      end
      ST_HUNT_RD, ST_CHK_RD, ST_EMIT_RD: begin
        rd_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sof   <= SOF_RESET;
      head  <= '0;
      fill  <= '0;
      idx   <= '0;
      ok    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) sof <= cfg_wr_data;

      case (state)
        ST_IDLE: begin
          if (accept) fill <= fill + FW'(1);
        end
        ST_HUNT_CMP: begin
          // drop a head byte that is not the start byte
          if (!sof_hit) begin
            head <= (head == HEAD_LAST) ? '0 : head + AW'(1);
            fill <= fill - FW'(1);
          end else if (fill == FILL_FULL) begin
            ok  <= 1'b1;
            c8  <= CRC8_SEED;
            c16 <= CRC16_SEED;
          end
        end
        ST_CHK_USE: begin
          ok <= ok_next;
          if (idx < IDX_CRC8)  c8  <= crc8_byte(c8, rd_data);
          if (idx < IDX_CRC_L) c16 <= crc16_byte(c16, rd_data);
          idx <= (idx == IDX_LAST) ? '0 : idx + AW'(1);
        end
        ST_EMIT_LD: begin
          if (slot_free) idx <= (idx == IDX_LAST) ? '0 : idx + AW'(1);
        end
        ST_DROP: begin
          head <= (head == HEAD_LAST) ? '0 : head + AW'(1);
          fill <= fill - FW'(1);
        end
        default: ;
      endcase
    end
  end

  // Output register: hold a transfer until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_EMIT_LD && slot_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT_LD && slot_free) begin
      out_byte  <= rd_data;
      out_index <= INDEX_W'(idx);
      out_last  <= (idx == IDX_LAST);
    end
  end

  assign m_axis_tdata = {4'h0, out_index, out_byte};
  assign m_axis_tlast = out_last;

endmodule
